// ----- sv/mss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types, codes and helpers of the motor safety supervisor.
// ----------------------------------------------------------------------------
package mss_pkg;

    // operating modes as seen on the result stream
    localparam logic [2:0] MODE_DISABLED  = 3'd0;
    localparam logic [2:0] MODE_DIRECT    = 3'd1;
    localparam logic [2:0] MODE_VELOCITY  = 3'd2;
    localparam logic [2:0] MODE_CURRENT   = 3'd3;
    localparam logic [2:0] MODE_SAFETY    = 3'd4;
    localparam logic [2:0] MODE_EMERGENCY = 3'd5;

    // request kinds
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_COMMAND = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_CRITICAL_CURRENT = 3'd0;
    localparam logic [2:0] REG_SAFETY_TRIP      = 3'd1;
    localparam logic [2:0] REG_SAFETY_DIVISOR   = 3'd2;
    localparam logic [2:0] REG_RESTORE          = 3'd3;
    localparam logic [2:0] REG_ALIVE_TIMEOUT    = 3'd4;
    localparam logic [2:0] REG_EMERG_DIVISOR    = 3'd5;
    localparam logic [2:0] REG_BRIDGE_OFF       = 3'd6;

    // serial divider
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // stream widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic        fire;
        logic [15:0] count;
    } cnt_res_t;

    // soft timer: count up, fire and wrap when count + 1 reaches the limit
    function automatic cnt_res_t run_count(input logic [15:0] c, input logic [15:0] limit);
        cnt_res_t    r;
        logic [16:0] n;
        n       = {1'b0, c} + 17'd1;
        r.fire  = (n >= {1'b0, limit});
        r.count = r.fire ? 16'd0 : n[15:0];
        return r;
    endfunction

endpackage

// ----- sv/motor_safety_supervisor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_safety_supervisor
// Mode supervisor with over-current trip, alive timeout, reference ramp-down
// and bridge shutdown, driven by tick and command transactions.
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// s_        in         s_tvalid/s_tready   tuser: req_type, tdata: current, mode, reference
// m_        out        m_tvalid/m_tready   tdata: mode, reference, bridge, taken
// cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// a command or a tick without ramp passes from ST_IDLE straight to ST_OUT
// a ramping tick passes ST_DIV, the one-bit-per-cycle divider, then ST_RAMP and ST_OUT
// s_tready is high only while idle; a held result stalls the sequencer
// aresetn is synchronous; control registers and timers start from their defaults
// the divider and result holding registers are not reset; cfg_ready is always high
// ----------------------------------------------------------------------------
module motor_safety_supervisor
    import mss_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // measured_current[15:0], requested_mode[17:16], reference_value[49:18]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // mode[2:0], reference_out[34:3], bridge_enable[35], command_taken[36]
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_RAMP = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [14:0] crit_reg;
    logic [15:0] trip_reg, sdiv_reg, restore_reg, alive_lim_reg, ediv_reg, boff_lim_reg;

    logic [2:0]         mode_reg, mode_next;
    logic [2:0]         smode_reg, smode_next;
    logic signed [31:0] active_reg, active_next;
    logic signed [31:0] sref_reg, sref_next;
    logic [15:0]        oc_cnt_reg, oc_cnt_next;
    logic [15:0]        rs_cnt_reg, rs_cnt_next;
    logic [15:0]        al_cnt_reg, al_cnt_next;
    logic [15:0]        bo_cnt_reg, bo_cnt_next;
    logic               taken_reg, taken_next;
    logic               m_tvalid_reg, m_tvalid_next;

    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic [15:0]          rem_reg, rem_next;
    logic [31:0]          quo_reg, quo_next;
    logic [15:0]          dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;

    logic [2:0]  m_mode_reg;
    logic [31:0] m_ref_reg;
    logic        m_bridge_reg, m_taken_reg;

    logic               accept;
    logic               out_free;
    logic signed [15:0] cur;
    logic        [1:0]  req_mode;
    logic signed [31:0] req_ref;
    logic signed [16:0] cur17;
    logic        [16:0] mag;
    logic               over;
    logic        [16:0] trial;
    logic signed [32:0] qs;
    logic signed [33:0] diff;
    logic signed [31:0] sat;
    cnt_res_t           r_oc, r_al, r_bo, r_rs;
    logic        [15:0] ramp_div;
    logic        [31:0] smag;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {3'b000, m_taken_reg, m_bridge_reg, m_ref_reg, m_mode_reg};

    assign cur      = s_tdata[15:0];
    assign req_mode = s_tdata[17:16];
    assign req_ref  = s_tdata[49:18];
    assign cur17    = {cur[15], cur};
    assign mag      = cur17[16] ? 17'(17'sd0 - cur17) : 17'(cur17);
    assign over     = (mag > {2'b00, crit_reg});

    assign trial = {rem_reg, quo_reg[31]};
    assign qs    = neg_reg ? (33'sd0 - $signed({1'b0, quo_reg})) : $signed({1'b0, quo_reg});
    assign diff  = 34'(active_reg) - 34'(qs);

    always_comb begin
        if (diff[33:31] != 3'b000 && diff[33:31] != 3'b111) begin
            sat = diff[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sat = diff[31:0];
        end
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        smode_next    = smode_reg;
        active_next   = active_reg;
        sref_next     = sref_reg;
        oc_cnt_next   = oc_cnt_reg;
        rs_cnt_next   = rs_cnt_reg;
        al_cnt_next   = al_cnt_reg;
        bo_cnt_next   = bo_cnt_reg;
        taken_next    = taken_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        dcnt_next     = dcnt_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvs_next      = dvs_reg;
        neg_next      = neg_reg;
        r_oc          = '0;
        r_al          = '0;
        r_bo          = '0;
        r_rs          = '0;
        ramp_div      = 16'd1;
        smag          = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_OUT;
                    taken_next = 1'b0;
                    if (s_tuser == REQ_TICK) begin
                        if (mode_next inside {[MODE_DIRECT:MODE_CURRENT]}) begin
                            if (over) begin
                                r_oc        = run_count(oc_cnt_next, trip_reg);
                                oc_cnt_next = r_oc.count;
                                if (r_oc.fire) begin
                                    smode_next = mode_next;
                                    mode_next  = MODE_SAFETY;
                                    sref_next  = active_reg;
                                end
                            end else begin
                                oc_cnt_next = '0;
                            end
                        end
                        if (mode_next != MODE_EMERGENCY && mode_next != MODE_DISABLED) begin
                            r_al        = run_count(al_cnt_next, alive_lim_reg);
                            al_cnt_next = r_al.count;
                            if (r_al.fire) begin
                                if (restore_reg == 16'd0 && mode_next == MODE_SAFETY) begin
                                    oc_cnt_next = '0;
                                end
                                mode_next   = MODE_EMERGENCY;
                                sref_next   = active_reg;
                                bo_cnt_next = '0;
                            end
                        end
                        if (mode_next == MODE_EMERGENCY) begin
                            if (active_reg != 32'sd0) begin
                                ramp_div   = ediv_reg;
                                state_next = ST_DIV;
                            end else begin
                                r_bo        = run_count(bo_cnt_next, boff_lim_reg);
                                bo_cnt_next = r_bo.count;
                                if (r_bo.fire) begin
                                    mode_next = MODE_DISABLED;
                                end
                            end
                        end else if (mode_next == MODE_SAFETY) begin
                            if (over) begin
                                rs_cnt_next = '0;
                                if (active_reg != 32'sd0) begin
                                    ramp_div   = sdiv_reg;
                                    state_next = ST_DIV;
                                end
                            end else if (restore_reg != 16'd0) begin
                                r_rs        = run_count(rs_cnt_next, restore_reg);
                                rs_cnt_next = r_rs.count;
                                if (r_rs.fire) begin
                                    oc_cnt_next = '0;
                                    mode_next   = smode_next;
                                end
                            end
                        end
                        smag      = sref_next[31] ? (32'd0 - 32'(sref_next)) : 32'(sref_next);
                        dcnt_next = '0;
                        rem_next  = '0;
                        quo_next  = smag;
                        dvs_next  = (ramp_div == 16'd0) ? 16'd1 : ramp_div;
                        neg_next  = sref_next[31];
                    end else begin
                        if (mode_reg != MODE_SAFETY) begin
                            mode_next   = {1'b0, req_mode};
                            active_next = req_ref;
                            taken_next  = 1'b1;
                        end
                        al_cnt_next = '0;
                    end
                end
            end
            ST_DIV: begin
                if (trial >= {1'b0, dvs_reg}) begin
                    rem_next = 16'(trial - {1'b0, dvs_reg});
                    quo_next = {quo_reg[30:0], 1'b1};
                end else begin
                    rem_next = trial[15:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_RAMP;
                end
            end
            ST_RAMP: begin
                if ((sat > 32'sd0 && sref_reg < 32'sd0) || (sat < 32'sd0 && sref_reg > 32'sd0)) begin
                    active_next = 32'sd0;
                end else begin
                    active_next = sat;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            crit_reg      <= 15'd32767;
            trip_reg      <= 16'd1000;
            sdiv_reg      <= 16'd100;
            restore_reg   <= 16'd0;
            alive_lim_reg <= 16'd1000;
            ediv_reg      <= 16'd1000;
            boff_lim_reg  <= 16'd1000;
            mode_reg      <= MODE_DISABLED;
            smode_reg     <= MODE_DISABLED;
            active_reg    <= '0;
            sref_reg      <= '0;
            oc_cnt_reg    <= '0;
            rs_cnt_reg    <= '0;
            al_cnt_reg    <= '0;
            bo_cnt_reg    <= '0;
            taken_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            smode_reg    <= smode_next;
            active_reg   <= active_next;
            sref_reg     <= sref_next;
            oc_cnt_reg   <= oc_cnt_next;
            rs_cnt_reg   <= rs_cnt_next;
            al_cnt_reg   <= al_cnt_next;
            bo_cnt_reg   <= bo_cnt_next;
            taken_reg    <= taken_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CRITICAL_CURRENT: crit_reg      <= cfg_data[14:0];
                    REG_SAFETY_TRIP:      trip_reg      <= cfg_data;
                    REG_SAFETY_DIVISOR:   sdiv_reg      <= cfg_data;
                    REG_RESTORE:          restore_reg   <= cfg_data;
                    REG_ALIVE_TIMEOUT:    alive_lim_reg <= cfg_data;
                    REG_EMERG_DIVISOR:    ediv_reg      <= cfg_data;
                    REG_BRIDGE_OFF:       boff_lim_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // divider datapath and result holding register
    always_ff @(posedge aclk) begin
        dcnt_reg <= dcnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        if (state_reg == ST_OUT && out_free) begin
            m_mode_reg   <= mode_reg;
            m_ref_reg    <= active_reg;
            m_bridge_reg <= (mode_reg != MODE_DISABLED);
            m_taken_reg  <= taken_reg;
        end
    end

endmodule

// ----- sv/mss_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_checker
// Port-level checks of the motor safety supervisor, bound to its top level.
// ----------------------------------------------------------------------------
module mss_checker
    import mss_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // bridge enable follows the reported mode
    a_bridge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[35] == (m_tdata[2:0] != MODE_DISABLED)))
        else $error("bridge enable does not match mode");

    // reported mode is a defined mode
    a_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= MODE_EMERGENCY))
        else $error("undefined mode reported");

    // a taken command leaves a host mode in force
    a_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[36]) |-> (m_tdata[2:0] <= MODE_CURRENT))
        else $error("taken command with supervisor mode");

    // one transaction at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind motor_safety_supervisor mss_checker u_mss_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for motor_safety_supervisor. Tick and command
// transactions are streamed in with random gaps, and the result stream is
// taken with random back-pressure. A behavioral supervisor inside the bench
// predicts mode, reference, bridge enable and command-taken for each accepted
// transaction, and every result is checked against it. A short directed
// sequence walks through trip, restore, alive timeout, ramp-down and bridge
// shutdown. Random phases under changing register settings follow.
// ----------------------------------------------------------------------------
module testbench;
    import mss_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        bit                 is_cfg;
        logic [2:0]         idx;
        logic [15:0]        val;
        logic               req;
        logic signed [15:0] cur;
        logic [1:0]         mode;
        logic signed [31:0] refv;
    } drive_op_t;

    typedef struct {
        logic [2:0]         mode;
        logic signed [31:0] refo;
        logic               bridge;
        logic               taken;
    } status_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [2:0]           cfg_index;
    logic [15:0]          cfg_data;

    drive_op_t pending_ops[$];
    status_t   expected_status[$];

    // supervisor state as predicted
    logic [15:0]        cfg_reg [0:7];
    logic [2:0]         p_mode;
    logic [2:0]         p_saved_mode;
    logic signed [31:0] p_ref;
    logic signed [31:0] p_saved_ref;
    logic [15:0]        oc_cnt;
    logic [15:0]        rs_cnt;
    logic [15:0]        alive_cnt;
    logic [15:0]        boff_cnt;

    int  gen_crit;
    int  n_ticks;
    int  n_cmds;
    int  n_cfg_writes;
    int  n_items_issued;
    int  n_items_in;
    int  n_cfg_issued;
    int  n_cfg_done;
    int  n_results;
    int  n_results_seen;
    int  n_errors;
    int  mode_hits [0:7];
    int  src_wait;
    int  sink_wait;
    int  quiet_cycles;
    bit  s_busy;
    bit  c_busy;
    bit  src_idle;
    bit  sink_idle;

    motor_safety_supervisor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        n_errors++;
    endtask

    function automatic bit timer_step(inout logic [15:0] cnt, input logic [15:0] limit);
        logic [16:0] nxt;
        nxt = {1'b0, cnt} + 17'd1;
        if (nxt >= {1'b0, limit}) begin
            cnt = '0;
            return 1'b1;
        end
        cnt = nxt[15:0];
        return 1'b0;
    endfunction

    function automatic void switch_mode(input logic [2:0] m);
        if (cfg_reg[REG_RESTORE] == 16'd0 && p_mode == MODE_SAFETY && m != MODE_SAFETY) begin
            oc_cnt = '0;
        end
        p_mode = m;
        if (m == MODE_SAFETY || m == MODE_EMERGENCY) begin
            p_saved_ref = p_ref;
        end
    endfunction

    function automatic void ramp_down(input logic [15:0] divisor);
        longint d;
        longint n;
        d = (divisor == 16'd0) ? 1 : divisor;
        if (p_ref == 0) return;
        n = longint'(p_ref) - longint'(p_saved_ref) / d;
        if (n > 64'sd2147483647) n = 64'sd2147483647;
        if (n < -64'sd2147483648) n = -64'sd2147483648;
        if ((n > 0 && p_saved_ref < 0) || (n < 0 && p_saved_ref > 0)) n = 0;
        p_ref = 32'(n);
    endfunction

    function automatic status_t supervise_item(input logic req, input logic signed [15:0] cur,
                                               input logic [1:0] req_mode,
                                               input logic signed [31:0] refv);
        status_t     r;
        logic [15:0] mag;
        logic        over;
        r.taken = 1'b0;
        if (req == REQ_TICK) begin
            mag  = cur[15] ? 16'(-cur) : cur;
            over = mag > {1'b0, cfg_reg[REG_CRITICAL_CURRENT][14:0]};
            if (p_mode >= MODE_DIRECT && p_mode <= MODE_CURRENT) begin
                if (over) begin
                    if (timer_step(oc_cnt, cfg_reg[REG_SAFETY_TRIP])) begin
                        p_saved_mode = p_mode;
                        switch_mode(MODE_SAFETY);
                    end
                end else begin
                    oc_cnt = '0;
                end
            end
            if (p_mode != MODE_EMERGENCY && p_mode != MODE_DISABLED) begin
                if (timer_step(alive_cnt, cfg_reg[REG_ALIVE_TIMEOUT])) begin
                    switch_mode(MODE_EMERGENCY);
                    boff_cnt = '0;
                end
            end
            if (p_mode == MODE_EMERGENCY) begin
                if (p_ref != 0) begin
                    ramp_down(cfg_reg[REG_EMERG_DIVISOR]);
                end else if (timer_step(boff_cnt, cfg_reg[REG_BRIDGE_OFF])) begin
                    switch_mode(MODE_DISABLED);
                end
            end else if (p_mode == MODE_SAFETY) begin
                if (over) begin
                    ramp_down(cfg_reg[REG_SAFETY_DIVISOR]);
                    rs_cnt = '0;
                end else if (cfg_reg[REG_RESTORE] != 16'd0) begin
                    if (timer_step(rs_cnt, cfg_reg[REG_RESTORE])) begin
                        oc_cnt = '0;
                        switch_mode(p_saved_mode);
                    end
                end
            end
        end else begin
            if (p_mode != MODE_SAFETY) begin
                if ({1'b0, req_mode} != p_mode) switch_mode({1'b0, req_mode});
                p_ref   = refv;
                r.taken = 1'b1;
            end
            alive_cnt = '0;
        end
        r.mode   = p_mode;
        r.refo   = p_ref;
        r.bridge = (p_mode != MODE_DISABLED);
        return r;
    endfunction

    task automatic push_cfg(input logic [2:0] idx, input logic [15:0] val);
        drive_op_t op;
        op = '{is_cfg: 1'b1, idx: idx, val: val, req: 1'b0, cur: '0, mode: '0, refv: '0};
        pending_ops.push_back(op);
        if (idx == REG_CRITICAL_CURRENT) gen_crit = val & 16'h7fff;
        n_cfg_writes++;
    endtask

    task automatic push_tick(input logic signed [15:0] cur);
        drive_op_t op;
        op = '{is_cfg: 1'b0, idx: '0, val: '0, req: REQ_TICK, cur: cur, mode: '0, refv: '0};
        pending_ops.push_back(op);
        n_ticks++;
    endtask

    task automatic push_cmd(input logic [1:0] mode, input logic signed [31:0] refv);
        drive_op_t op;
        op = '{is_cfg: 1'b0, idx: '0, val: '0, req: REQ_COMMAND, cur: 16'($urandom),
               mode: mode, refv: refv};
        pending_ops.push_back(op);
        n_cmds++;
    endtask

    function automatic logic signed [15:0] pick_current(input bit hot);
        int mag;
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        if (hot) mag = $urandom_range(gen_crit + 1, 32768);
        else mag = $urandom_range(0, gen_crit);
        if ($urandom_range(0, 1) == 1 || mag == 32768) return 16'(-mag);
        return 16'(mag);
    endfunction

    task automatic load_settings(input int kind);
        logic [15:0] v;
        int          i;
        if (kind < 2) begin
            v = (kind == 0) ? 16'h0000 : 16'hffff;
            for (i = 0; i < 7; i++) push_cfg(3'(i), v);
        end else begin
            push_cfg(REG_CRITICAL_CURRENT, 16'($urandom));
            push_cfg(REG_SAFETY_TRIP, 16'($urandom_range(1, 6)));
            push_cfg(REG_SAFETY_DIVISOR, ($urandom_range(0, 3) == 0) ?
                     16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 8)));
            push_cfg(REG_RESTORE, 16'($urandom_range(0, 6)));
            push_cfg(REG_ALIVE_TIMEOUT, 16'($urandom_range(2, 16)));
            push_cfg(REG_EMERG_DIVISOR, ($urandom_range(0, 3) == 0) ?
                     16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 8)));
            push_cfg(REG_BRIDGE_OFF, 16'($urandom_range(1, 6)));
        end
    endtask

    // well-formed runs: commands, mostly into active modes, mixed with runs of hot or cold ticks
    task automatic random_phase(input int n_items);
        int               made;
        int               cmd_odds;
        bit               hot;
        logic signed [31:0] refv;
        made     = 0;
        hot      = 1'b0;
        cmd_odds = $urandom_range(3, 10);
        while (made < n_items) begin
            if ($urandom_range(0, cmd_odds - 1) == 0) begin
                if ($urandom_range(0, 1) == 1) refv = $urandom;
                else refv = $signed($urandom_range(0, 2000)) - 1000;
                push_cmd(($urandom_range(0, 9) == 0) ? 2'(MODE_DISABLED) :
                         2'($urandom_range(1, 3)), refv);
            end else begin
                if ($urandom_range(0, 4) == 0) hot = !hot;
                push_tick(pick_current(hot));
            end
            made++;
        end
    endtask

    // source side
    always @(negedge aclk) begin
        drive_op_t op;
        if (aresetn) begin
            if (s_busy && n_items_in == n_items_issued) s_busy = 1'b0;
            if (c_busy && n_cfg_done == n_cfg_issued) c_busy = 1'b0;
            if (!s_busy && !c_busy) begin
                if (src_wait > 0) begin
                    src_wait--;
                end else if (pending_ops.size() > 0) begin
                    if (pending_ops[0].is_cfg) begin
                        if (expected_status.size() == 0) begin
                            op = pending_ops.pop_front();
                            c_busy = 1'b1;
                            n_cfg_issued++;
                            cfg_index <= op.idx;
                            cfg_data  <= op.val;
                        end
                    end else begin
                        op = pending_ops.pop_front();
                        s_busy = 1'b1;
                        n_items_issued++;
                        s_tuser <= op.req;
                        s_tdata <= {6'b0, op.refv, op.mode, op.cur};
                        if ($urandom_range(0, 39) == 0) src_idle = !src_idle;
                        src_wait = src_idle ? $urandom_range(0, 9) : 0;
                    end
                end
            end
        end
        s_tvalid  <= s_busy;
        cfg_valid <= c_busy;
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (n_results != n_results_seen) begin
            n_results_seen = n_results;
            if ($urandom_range(0, 39) == 0) sink_idle = !sink_idle;
            sink_wait = sink_idle ? $urandom_range(0, 9) : 0;
        end
        if (sink_wait > 0) begin
            sink_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        status_t            want;
        logic [2:0]         got_mode;
        logic signed [31:0] got_ref;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_mode = m_tdata[2:0];
                got_ref  = m_tdata[34:3];
                n_results++;
                mode_hits[got_mode]++;
                if (expected_status.size() == 0) begin
                    report_error("result transaction with no expectation pending");
                end else begin
                    want = expected_status.pop_front();
                    if (got_mode !== want.mode)
                        report_error($sformatf("mode got %0d want %0d", got_mode, want.mode));
                    if (got_ref !== want.refo)
                        report_error($sformatf("reference got %0d want %0d", got_ref, want.refo));
                    if (m_tdata[35] !== want.bridge)
                        report_error($sformatf("bridge_enable got %b want %b",
                                               m_tdata[35], want.bridge));
                    if (m_tdata[36] !== want.taken)
                        report_error($sformatf("command_taken got %b want %b",
                                               m_tdata[36], want.taken));
                end
            end
            if (s_tvalid && s_tready) begin
                expected_status.push_back(supervise_item(s_tuser, s_tdata[15:0],
                                                         s_tdata[17:16], s_tdata[49:18]));
                n_items_in++;
            end
            if (cfg_valid && cfg_ready) begin
                cfg_reg[cfg_index] = (cfg_index == REG_CRITICAL_CURRENT) ?
                                     {1'b0, cfg_data[14:0]} : cfg_data;
                n_cfg_done++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                             quiet_cycles, expected_status.size());
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    initial begin
        int k;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        for (k = 0; k < 8; k++) begin
            cfg_reg[k]   = '0;
            mode_hits[k] = 0;
        end
        cfg_reg[REG_CRITICAL_CURRENT] = 16'd32767;
        cfg_reg[REG_SAFETY_TRIP]      = 16'd1000;
        cfg_reg[REG_SAFETY_DIVISOR]   = 16'd100;
        cfg_reg[REG_ALIVE_TIMEOUT]    = 16'd1000;
        cfg_reg[REG_EMERG_DIVISOR]    = 16'd1000;
        cfg_reg[REG_BRIDGE_OFF]       = 16'd1000;
        p_mode       = MODE_DISABLED;
        p_saved_mode = MODE_DISABLED;
        p_ref        = '0;
        p_saved_ref  = '0;
        oc_cnt       = '0;
        rs_cnt       = '0;
        alive_cnt    = '0;
        boff_cnt     = '0;
        gen_crit     = 32767;

        // directed: reset defaults, then a full trip / restore / timeout / shutdown walk
        push_tick(16'sd0);
        push_cmd(2'(MODE_DIRECT), 32'sh7fffffff);
        push_tick(16'sd12345);
        push_cfg(REG_CRITICAL_CURRENT, 16'd1000);
        push_cfg(REG_SAFETY_TRIP, 16'd2);
        push_cfg(REG_SAFETY_DIVISOR, 16'd4);
        push_cfg(REG_RESTORE, 16'd2);
        push_cfg(REG_ALIVE_TIMEOUT, 16'd6);
        push_cfg(REG_EMERG_DIVISOR, 16'd2);
        push_cfg(REG_BRIDGE_OFF, 16'd2);
        push_tick(-16'sd32768);
        push_tick(16'sd32767);
        push_cmd(2'(MODE_VELOCITY), 32'sd5);
        push_tick(16'sd0);
        push_tick(16'sd1000);
        push_cmd(2'(MODE_CURRENT), -32'sh80000000);
        push_tick(-16'sd1000);
        push_tick(16'sd999);
        push_tick(16'sd0);
        push_tick(16'sd1);
        push_tick(-16'sd1);
        push_tick(16'sd0);
        for (k = 0; k < 4; k++) push_tick(16'sd0);
        push_cmd(2'(MODE_DIRECT), -32'sd7);
        push_cmd(2'(MODE_DIRECT), -32'sd7);
        push_cmd(2'(MODE_DISABLED), 32'sd0);
        push_cmd(2'(MODE_VELOCITY), 32'sd1);

        for (k = 0; k < 10; k++) begin
            load_settings(k);
            if (k == 2) push_cfg(REG_UNUSED, 16'($urandom));
            random_phase(70);
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        while (pending_ops.size() > 0 || s_busy || c_busy || expected_status.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("covered %0d ticks, %0d commands and %0d register writes; %0d results checked",
                 n_ticks, n_cmds, n_cfg_writes, n_results);
        $display("results seen in safety %0d, in emergency %0d, with bridge off %0d",
                 mode_hits[MODE_SAFETY], mode_hits[MODE_EMERGENCY], mode_hits[MODE_DISABLED]);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
